/* rtl/rtwa_pkg.sv */
package rtwa_pkg;

  localparam int unsigned SECOND_CLUSTER_FIRST_CPU = 4;
  localparam int unsigned NUM_CPUS                 = 8;
  localparam bit          SECOND_FITS              = (NUM_CPUS > SECOND_CLUSTER_FIRST_CPU);

  localparam int unsigned CNT_W   = 10;
  localparam int unsigned CPU_W   = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned AVG_W   = 17;
  localparam int unsigned SCALE   = 100;
  localparam int unsigned AVG_MAX = 102300;
  localparam int unsigned PROD_W  = AVG_W + TIME_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned DIV_W   = TIME_W + 1;
  localparam int unsigned ITER_W  = $clog2(AVG_W);

  localparam logic [CPU_W-1:0] LEAD_CPU_0 = '0;
  localparam logic [CPU_W-1:0] LEAD_CPU_1 = CPU_W'(SECOND_CLUSTER_FIRST_CPU);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_PREP  = 3'd0;
  localparam step_t STEP_MUL_A = 3'd1;
  localparam step_t STEP_MUL_B = 3'd2;
  localparam step_t STEP_SUM   = 3'd3;
  localparam step_t STEP_DIV   = 3'd4;
  localparam step_t STEP_WR_Q  = 3'd5;
  localparam step_t STEP_WR_C  = 3'd6;
  localparam step_t STEP_READ  = 3'd7;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_CUR_DT,
    MUL_AVG_TOT
  } mul_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_QUO,
    WR_CUR
  } wr_sel_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_TRIVIAL,
    JMP_LOOP,
    JMP_CLUSTER,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic     prep;
    mul_sel_t mul;
    logic     acc_load;
    logic     sum_init;
    logic     div_step;
    wr_sel_t  wr;
    logic     rd;
    jmp_t     jmp;
    step_t    target;
  } uword_t;

  typedef struct packed {
    uword_t word;
    logic   exec;
    logic   cl;
  } ctl_t;

  typedef struct packed {
    logic trivial;
    logic out_blocked;
    logic second_on;
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      STEP_PREP: begin
        w.prep = 1'b1;
        w.jmp  = JMP_NEXT;
      end
      STEP_MUL_A: begin
        w.mul    = MUL_CUR_DT;
        w.jmp    = JMP_TRIVIAL;
        w.target = STEP_WR_C;
      end
      STEP_MUL_B: begin
        w.mul      = MUL_AVG_TOT;
        w.acc_load = 1'b1;
        w.jmp      = JMP_NEXT;
      end
      STEP_SUM: begin
        w.sum_init = 1'b1;
        w.jmp      = JMP_NEXT;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.jmp      = JMP_LOOP;
        w.target   = STEP_DIV;
      end
      STEP_WR_Q: begin
        w.wr     = WR_QUO;
        w.jmp    = JMP_CLUSTER;
        w.target = STEP_PREP;
      end
      STEP_WR_C: begin
        w.wr     = WR_CUR;
        w.jmp    = JMP_CLUSTER;
        w.target = STEP_PREP;
      end
      STEP_READ: begin
        w.rd  = 1'b1;
        w.jmp = JMP_WAIT_OUT;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/rtwa_if.sv */
interface rtwa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [rtwa_pkg::CPU_W-1:0]   cpu;
  logic [rtwa_pkg::CNT_W-1:0]   running_first_cluster;
  logic [rtwa_pkg::CNT_W-1:0]   running_second_cluster;
  logic [rtwa_pkg::TIME_W-1:0]  now_ms;

  modport source (
    output valid, operation, cpu, running_first_cluster, running_second_cluster, now_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, cpu, running_first_cluster, running_second_cluster, now_ms,
    output ready
  );
endinterface

interface rtwa_out_if;
  logic                        valid;
  logic                        ready;
  logic [rtwa_pkg::AVG_W-1:0]  average_runnable;

  modport source (
    output valid, average_runnable,
    input  ready
  );
  modport sink (
    input  valid, average_runnable,
    output ready
  );
endinterface

/* rtl/rtwa_seq.sv */
module rtwa_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              start_op,
  input  rtwa_pkg::stat_t   stat,
  output logic              busy,
  output rtwa_pkg::ctl_t    ctl
);

  rtwa_pkg::seq_state_t       state_r, state_nxt;
  rtwa_pkg::step_t            pc_r, pc_nxt;
  logic                       cl_r, cl_nxt;
  logic [rtwa_pkg::ITER_W-1:0] iter_r, iter_nxt;
  rtwa_pkg::uword_t           word;
  logic                       run;

  assign word = rtwa_pkg::ucode(pc_r);
  assign run  = (state_r == rtwa_pkg::ST_RUN);
  assign busy = run;

  assign ctl.word = word;
  assign ctl.cl   = cl_r;
  assign ctl.exec = run && !(word.jmp == rtwa_pkg::JMP_WAIT_OUT && stat.out_blocked);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cl_nxt    = cl_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      rtwa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = rtwa_pkg::ST_RUN;
          pc_nxt    = (start_op == rtwa_pkg::OP_READ) ? rtwa_pkg::STEP_READ
                                                      : rtwa_pkg::STEP_PREP;
          cl_nxt    = 1'b0;
        end
      end
      rtwa_pkg::ST_RUN: begin
        if (word.sum_init) begin
          iter_nxt = rtwa_pkg::ITER_W'(rtwa_pkg::AVG_W - 1);
        end
        unique case (word.jmp)
          rtwa_pkg::JMP_NEXT: begin
            pc_nxt = rtwa_pkg::step_t'(pc_r + 3'd1);
          end
          rtwa_pkg::JMP_TRIVIAL: begin
            pc_nxt = stat.trivial ? word.target : rtwa_pkg::step_t'(pc_r + 3'd1);
          end
          rtwa_pkg::JMP_LOOP: begin
            if (iter_r != '0) begin
              iter_nxt = iter_r - rtwa_pkg::ITER_W'(1);
              pc_nxt   = word.target;
            end else begin
              pc_nxt = rtwa_pkg::step_t'(pc_r + 3'd1);
            end
          end
          rtwa_pkg::JMP_CLUSTER: begin
            if (!cl_r && stat.second_on) begin
              cl_nxt = 1'b1;
              pc_nxt = word.target;
            end else begin
              state_nxt = rtwa_pkg::ST_IDLE;
            end
          end
          rtwa_pkg::JMP_WAIT_OUT: begin
            if (!stat.out_blocked) begin
              state_nxt = rtwa_pkg::ST_IDLE;
            end
          end
          default: begin
            state_nxt = rtwa_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = rtwa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtwa_pkg::ST_IDLE;
      pc_r    <= rtwa_pkg::STEP_PREP;
      cl_r    <= 1'b0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cl_r    <= cl_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

/* rtl/rtwa_dp.sv */
module rtwa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [rtwa_pkg::CPU_W-1:0]    cpu,
  input  logic [rtwa_pkg::CNT_W-1:0]    cnt0,
  input  logic [rtwa_pkg::CNT_W-1:0]    cnt1,
  input  logic [rtwa_pkg::TIME_W-1:0]   now,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  rtwa_pkg::ctl_t                ctl,
  output rtwa_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtwa_pkg::AVG_W-1:0]    out_avg
);

  logic [rtwa_pkg::CPU_W-1:0]  cpu_r;
  logic [rtwa_pkg::CNT_W-1:0]  cnt0_r, cnt1_r;
  logic [rtwa_pkg::TIME_W-1:0] now_r;
  logic                        second_en_r;

  logic [rtwa_pkg::AVG_W-1:0]  avg_r   [2];
  logic [rtwa_pkg::TIME_W-1:0] last_r  [2];
  logic [rtwa_pkg::TIME_W-1:0] total_r [2];

  logic [rtwa_pkg::TIME_W-1:0] dt_r, tot_r;
  logic [rtwa_pkg::AVG_W-1:0]  cur_r, wavg_r;
  logic [rtwa_pkg::PROD_W-1:0] prod_r, acc_r;
  logic [rtwa_pkg::DIV_W-1:0]  div_r, rem_r;
  logic [rtwa_pkg::AVG_W-1:0]  quo_r;
  logic                        out_valid_r;
  logic [rtwa_pkg::AVG_W-1:0]  out_avg_r;

  logic                        cl, ex, second_on;
  logic [rtwa_pkg::CNT_W-1:0]  cnt_sel;
  logic [rtwa_pkg::AVG_W-1:0]  cur_calc;
  logic [rtwa_pkg::TIME_W-1:0] last_eff, dt_calc, tot_calc;
  logic [rtwa_pkg::TIME_W-1:0] mul_a;
  logic [rtwa_pkg::AVG_W-1:0]  mul_b;
  logic [rtwa_pkg::SUM_W-1:0]  sum;
  logic [rtwa_pkg::DIV_W:0]    trial;
  logic [rtwa_pkg::DIV_W:0]    trial_sub;
  logic [rtwa_pkg::DIV_W-1:0]  tsum;
  logic [rtwa_pkg::TIME_W-1:0] tot_new;
  logic                        rd_fire;
  logic                        rd_hit0, rd_hit1;
  logic [rtwa_pkg::AVG_W-1:0]  rd_val;

  assign cl        = ctl.cl;
  assign ex        = ctl.exec;
  assign second_on = second_en_r && rtwa_pkg::SECOND_FITS;

  // per-cluster preparation
  assign cnt_sel  = cl ? cnt1_r : cnt0_r;
  assign cur_calc = rtwa_pkg::AVG_W'({7'd0, cnt_sel} * rtwa_pkg::AVG_W'(rtwa_pkg::SCALE));
  assign last_eff = (last_r[cl] == '0) ? now_r : last_r[cl];
  assign dt_calc  = now_r - last_eff;
  assign tot_calc = (avg_r[cl] == '0) ? '0 : total_r[cl];

  assign mul_a = (ctl.word.mul == rtwa_pkg::MUL_CUR_DT) ? dt_r : tot_r;
  assign mul_b = (ctl.word.mul == rtwa_pkg::MUL_CUR_DT) ? cur_r : wavg_r;

  assign sum = {1'b0, acc_r} + {1'b0, prod_r};

  // restoring divide, one quotient bit per step
  assign trial     = {rem_r, quo_r[rtwa_pkg::AVG_W-1]};
  assign trial_sub = trial - {1'b0, div_r};

  assign tsum    = {1'b0, dt_r} + {1'b0, tot_r};
  assign tot_new = tsum[rtwa_pkg::TIME_W] ? '1 : tsum[rtwa_pkg::TIME_W-1:0];

  assign rd_fire = ex && ctl.word.rd;
  assign rd_hit0 = (cpu_r == rtwa_pkg::LEAD_CPU_0);
  assign rd_hit1 = (cpu_r == rtwa_pkg::LEAD_CPU_1) && second_on;

  always_comb begin
    priority if (rd_hit0) begin
      rd_val = avg_r[0];
    end else if (rd_hit1) begin
      rd_val = avg_r[1];
    end else begin
      rd_val = '0;
    end
  end

  assign stat.trivial     = (dt_r == '0) || (tot_r == '0);
  assign stat.out_blocked = out_valid_r && !out_ready;
  assign stat.second_on   = second_on;

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cpu_r  <= cpu;
      cnt0_r <= cnt0;
      cnt1_r <= cnt1;
      now_r  <= now;
    end
    if (ex && ctl.word.prep) begin
      dt_r   <= dt_calc;
      tot_r  <= tot_calc;
      cur_r  <= cur_calc;
      wavg_r <= avg_r[cl];
    end
    if (ex && ctl.word.mul != rtwa_pkg::MUL_NONE) begin
      prod_r <= rtwa_pkg::PROD_W'(mul_a) * rtwa_pkg::PROD_W'(mul_b);
    end
    if (ex && ctl.word.acc_load) begin
      acc_r <= prod_r;
    end
    if (ex && ctl.word.sum_init) begin
      rem_r <= sum[rtwa_pkg::SUM_W-1:rtwa_pkg::AVG_W];
      quo_r <= sum[rtwa_pkg::AVG_W-1:0];
      div_r <= tsum;
    end else if (ex && ctl.word.div_step) begin
      if (!trial_sub[rtwa_pkg::DIV_W]) begin
        rem_r <= trial_sub[rtwa_pkg::DIV_W-1:0];
        quo_r <= {quo_r[rtwa_pkg::AVG_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[rtwa_pkg::DIV_W-1:0];
        quo_r <= {quo_r[rtwa_pkg::AVG_W-2:0], 1'b0};
      end
    end
    if (rd_fire) begin
      out_avg_r <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_en_r <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        avg_r[i]   <= '0;
        last_r[i]  <= '0;
        total_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        second_en_r <= cfg_wr_data;
      end
      if (rd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ex && ctl.word.wr != rtwa_pkg::WR_NONE) begin
        avg_r[cl]   <= (ctl.word.wr == rtwa_pkg::WR_QUO) ? quo_r : cur_r;
        last_r[cl]  <= now_r;
        total_r[cl] <= tot_new;
      end else if (rd_fire) begin
        if (rd_hit0) begin
          avg_r[0] <= '0;
        end else if (rd_hit1) begin
          avg_r[1] <= '0;
        end
      end
    end
  end

endmodule

/* rtl/runnable_time_weighted_average.sv */
// channel   dir   payload                                              handshake
// in_ch     in    operation, cpu, running_first/second_cluster, now_ms valid/ready
// out_ch    out   average_runnable (one per read request)               valid/ready
// cfg       in    cfg_wr_data = second_cluster_enable                  cfg_wr_en
//
// one request at a time; in_ch.ready is low while the microcode runs
// sample per enabled cluster: prep, multiply, current value written if time or
//   history is zero, else multiply, sum, 17-step restoring divide, quotient write
// read: held while a previous result waits on out_ch
// synchronous active-low reset; averages, times and history clear to zero
module runnable_time_weighted_average (
  input  logic            clk,
  input  logic            rst_n,
  rtwa_in_if.sink         in_ch,
  rtwa_out_if.source      out_ch,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data
);

  rtwa_pkg::ctl_t  ctl;
  rtwa_pkg::stat_t stat;
  logic            busy;
  logic            accept;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;

  rtwa_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .start_op (in_ch.operation),
    .stat     (stat),
    .busy     (busy),
    .ctl      (ctl)
  );

  rtwa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cpu         (in_ch.cpu),
    .cnt0        (in_ch.running_first_cluster),
    .cnt1        (in_ch.running_second_cluster),
    .now         (in_ch.now_ms),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_avg     (out_ch.average_runnable)
  );

endmodule

/* rtl/rtwa_chk.sv */
module rtwa_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rtwa_pkg::AVG_W-1:0]  out_avg
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_avg))
    else $error("stalled result changed");

  // result stays within the scaled range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_avg <= rtwa_pkg::AVG_W'(rtwa_pkg::AVG_MAX))
    else $error("average out of range");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // every request keeps the sequencer busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a sample request never makes a result
  a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == rtwa_pkg::OP_SAMPLE && !out_valid
    |=> !out_valid)
    else $error("result from sample request");

endmodule

bind runnable_time_weighted_average rtwa_chk u_rtwa_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_avg      (out_ch.average_runnable)
);
